// ----- hw/rtl/dbs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dbs_pkg;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dbs_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dbs_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire dbs_pkg::mem_ctl_t ctl_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dbs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dbs_ctrl #(
  parameter int unsigned MAX_ELEMENTS = 64,
  parameter int unsigned VALUE_WIDTH  = 32,
  localparam int unsigned AW = $clog2(MAX_ELEMENTS),
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1),
  localparam int unsigned IW = $clog2(MAX_ELEMENTS + 2)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  input  wire logic                   last_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        final_res_o,
  output dbs_pkg::mem_ctl_t           mem_ctl_o,
  output logic [AW-1:0]               waddr_o,
  output logic [VALUE_WIDTH-1:0]      wdata_o,
  output logic [AW-1:0]               raddr_o,
  input  wire logic [VALUE_WIDTH-1:0] rdata_i
);

  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_SORT    = 2'd1;
  localparam logic [1:0] ST_OUT_RD  = 2'd2;
  localparam logic [1:0] ST_OUT_VLD = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          len_q, len_d;
  logic [IW-1:0]          idx_q, idx_d;
  logic [AW-1:0]          oaddr_q, oaddr_d;
  logic [VALUE_WIDTH-1:0] carry_q, carry_d;

  logic          full;
  logic [CW-1:0] count_inc;
  logic [IW-1:0] len_ext;
  logic [IW-1:0] idx_m2;
  logic [CW-1:0] len_m1;
  logic [CW-1:0] count_m1;
  logic          swap;

  assign full      = (count_q == CW'(MAX_ELEMENTS));
  assign count_inc = full ? count_q : count_q + CW'(1);
  assign len_ext   = IW'(len_q);
  assign idx_m2    = idx_q - IW'(2);
  assign len_m1    = len_q - CW'(1);
  assign count_m1  = count_q - CW'(1);
  assign swap      = $signed(carry_q) < $signed(rdata_i);

  assign in_ready_o  = (state_q == ST_COLLECT);
  assign out_valid_o = (state_q == ST_OUT_VLD);
  assign final_res_o = (CW'(oaddr_q) == count_m1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    len_d     = len_q;
    idx_d     = idx_q;
    oaddr_d   = oaddr_q;
    carry_d   = carry_q;
    mem_ctl_o = '0;
    waddr_o   = count_q[AW-1:0];
    wdata_o   = value_i;
    raddr_o   = idx_q[AW-1:0];
    case (state_q)
      ST_COLLECT: begin
        if (in_valid_i) begin
          mem_ctl_o.wr_en = !full;
          count_d         = count_inc;
          if (last_i) begin
            len_d   = count_inc;
            idx_d   = '0;
            oaddr_d = '0;
            state_d = (count_inc >= CW'(2)) ? ST_SORT : ST_OUT_RD;
          end
        end
      end
      ST_SORT: begin
        mem_ctl_o.rd_en = (idx_q < len_ext);
        idx_d           = idx_q + IW'(1);
        if (idx_q == IW'(1)) begin
          carry_d = rdata_i;
        end
        if (idx_q >= IW'(2) && idx_q <= len_ext) begin
          mem_ctl_o.wr_en = 1'b1;
          waddr_o         = idx_m2[AW-1:0];
          wdata_o         = swap ? rdata_i : carry_q;
          carry_d         = swap ? carry_q : rdata_i;
        end
        if (idx_q == len_ext + IW'(1)) begin
          mem_ctl_o.wr_en = 1'b1;
          waddr_o         = len_m1[AW-1:0];
          wdata_o         = carry_q;
          idx_d           = '0;
          len_d           = len_m1;
          if (len_q == CW'(2)) begin
            state_d = ST_OUT_RD;
          end
        end
      end
      ST_OUT_RD: begin
        mem_ctl_o.rd_en = 1'b1;
        raddr_o         = oaddr_q;
        state_d         = ST_OUT_VLD;
      end
      ST_OUT_VLD: begin
        if (out_ready_i) begin
          if (final_res_o) begin
            count_d = '0;
            state_d = ST_COLLECT;
          end else begin
            oaddr_d = oaddr_q + AW'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      count_q <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      oaddr_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      oaddr_q <= oaddr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("output word offered while input open");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl_o.wr_en && mem_ctl_o.rd_en) |-> (waddr_o != raddr_o))
    else $error("read and write of the same entry in one cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_final_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && final_res_o) |=> in_ready_o)
    else $error("no return to collection after final word");

endmodule

`default_nettype wire

// ----- hw/rtl/descending_bubble_sort.sv -----
// Sorting: a set of n words is sorted in passes over L = n down to 2 words,
// paced by the single read and write port of the store.
// Output: each word is read from store, then offered until taken; n = 1 skips the sort.
// Input words are taken one per cycle while collecting; none during sort or output.
// Reset (rst_ni low, asynchronous) empties the set; store contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module descending_bubble_sort #(
  parameter int unsigned MAX_ELEMENTS = 64,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [VALUE_WIDTH-1:0] value_i,
  input  wire logic                          last_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0]      sorted_value_o,
  output logic                               final_res_o
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);

  dbs_pkg::mem_ctl_t      mem_ctl;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] rdata;

  dbs_ctrl #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .final_res_o(final_res_o),
    .mem_ctl_o  (mem_ctl),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  dbs_mem #(
    .DEPTH(MAX_ELEMENTS),
    .WIDTH(VALUE_WIDTH)
  ) u_mem (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign sorted_value_o = rdata;

endmodule

`default_nettype wire
